// ===== rtl/core/nrle_pkg.sv =====
// Shared types and constants for the netmask to reverse label encoder.
// Holds the request and result structs, label kind codes and zero-run types.
// No dependencies; every other file in rtl/core refers to it by scoped name.
`timescale 1ns / 1ps
`default_nettype none

package nrle_pkg;

  // Address geometry.
  localparam int NUM_WORDS = 8;
  localparam int WORD_W    = 16;
  localparam int IDX_W     = 3;
  localparam int RUN_W     = 4;

  // A run of zero words shorter than this is not compressed.
  localparam logic [RUN_W-1:0] MIN_ZERO_RUN = 4'd2;

  // Label kind codes.
  localparam logic [1:0] KIND_PREFIX = 2'd0;
  localparam logic [1:0] KIND_OCTET  = 2'd1;
  localparam logic [1:0] KIND_WORD   = 2'd2;
  localparam logic [1:0] KIND_ZRUN   = 2'd3;

  // One netmask request.
  typedef struct packed {
    logic        is_ipv6;
    logic [7:0]  prefix_length;
    logic [63:0] address_high;
    logic [63:0] address_low;
  } req_t;

  // One emitted label.
  typedef struct packed {
    logic [1:0]  label_kind;
    logic [15:0] label_value;
    logic        last_label;
  } res_t;

  // Per-lane run lengths, indexed by word position.
  typedef logic [NUM_WORDS-1:0][RUN_W-1:0] run_vec_t;

  // Chosen zero run handed from the merge stage to the emitter.
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] end_idx;
    logic [IDX_W-1:0] base_idx;
  } zrun_t;

endpackage

`default_nettype wire

// ===== rtl/core/nrle_lane.sv =====
// One word lane: reports the length of the maximal zero run that ends at
// this lane's word, or zero when none ends here or it is too short.
// Depends on nrle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrle_lane (
  input  wire logic [nrle_pkg::NUM_WORDS-1:0] zmask,
  input  wire logic [nrle_pkg::IDX_W-1:0]     lane_idx,
  output logic [nrle_pkg::RUN_W-1:0]          run_len
);

  logic                        is_end;
  logic                        active;
  logic [nrle_pkg::RUN_W-1:0]  cnt;

  // A run ends here when this word is zero and the next higher one is not.
  always_comb begin
    if (lane_idx == nrle_pkg::IDX_W'(nrle_pkg::NUM_WORDS - 1)) begin
      is_end = zmask[lane_idx];
    end else begin
      is_end = zmask[lane_idx] && !zmask[lane_idx + nrle_pkg::IDX_W'(1)];
    end
  end

  // Count zero words downward from this lane until the first nonzero word.
  always_comb begin
    active = is_end;
    cnt    = '0;
    for (int k = nrle_pkg::NUM_WORDS - 1; k >= 0; k--) begin
      if (nrle_pkg::IDX_W'(k) <= lane_idx && active) begin
        if (zmask[k]) begin
          cnt = cnt + nrle_pkg::RUN_W'(1);
        end else begin
          active = 1'b0;
        end
      end
    end
    run_len = (cnt >= nrle_pkg::MIN_ZERO_RUN) ? cnt : '0;
  end

endmodule

`default_nettype wire

// ===== rtl/core/nrle_merge.sv =====
// Merge stage: picks the longest zero run reported by the lanes, the
// highest-positioned run winning a tie. Depends on nrle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nrle_merge (
  input  wire nrle_pkg::run_vec_t runs,
  output nrle_pkg::zrun_t         best
);

  logic [nrle_pkg::RUN_W-1:0] best_len;
  logic [nrle_pkg::IDX_W-1:0] best_end;
  logic                       found;

  // Scan the lanes in order; a later run of equal length replaces the earlier.
  always_comb begin
    best_len = '0;
    best_end = '0;
    found    = 1'b0;
    for (int i = 0; i < nrle_pkg::NUM_WORDS; i++) begin
      if (runs[i] != '0 && runs[i] >= best_len) begin
        best_len = runs[i];
        best_end = nrle_pkg::IDX_W'(i);
        found    = 1'b1;
      end
    end
    best.found    = found;
    best.end_idx  = best_end;
    best.base_idx = nrle_pkg::IDX_W'({1'b0, best_end} + nrle_pkg::RUN_W'(1) - best_len);
  end

endmodule

`default_nettype wire

// ===== rtl/core/netmask_to_reverse_label_encoder_core.sv =====
// Netmask to reverse label encoder, top level: input stage, word lanes,
// merge stage and label emitter. Depends on nrle_pkg, nrle_lane, nrle_merge.
//
// A request is taken when start is high and busy is low. Each request leaves
// as a train of labels on consecutive cycles, one per cycle, marked by strobe:
// the prefix length first, then four octets (IPv4, five labels in all) or the
// IPv6 words last first with the longest zero run folded into one label (two
// to nine labels). The receiver cannot stall the output, and the single label
// emitter begins a new request's train right after the last label of the one
// before. A request moves through an input register and a lane register into
// the emitter. Two requests can wait behind the one being emitted, and busy
// rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module netmask_to_reverse_label_encoder_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire nrle_pkg::req_t  request,
  output logic                 strobe,
  output nrle_pkg::res_t       result
);

  // Input stage.
  logic                                 s1_valid;
  nrle_pkg::req_t                       s1_req;
  logic [127:0]                         s1_addr;
  logic [nrle_pkg::NUM_WORDS-1:0]       zmask;
  logic                                 s1_move;
  logic                                 accept;

  // Lane stage.
  logic                                 s2_valid;
  logic                                 s2_v6;
  logic [7:0]                           s2_plen;
  logic [127:0]                         s2_addr;
  nrle_pkg::run_vec_t                   s2_runs;
  nrle_pkg::run_vec_t                   lane_runs;
  nrle_pkg::zrun_t                      merged;
  logic                                 s2_move;

  // Emitter.
  logic                                 em_active;
  logic                                 em_prefix;
  logic                                 em_v6;
  logic [7:0]                           em_plen;
  logic [127:0]                         em_addr;
  logic [nrle_pkg::IDX_W-1:0]           em_idx;
  nrle_pkg::zrun_t                      em_zr;
  logic                                 em_last;
  logic                                 em_is_zr;
  logic [nrle_pkg::IDX_W-1:0]           em_idx_next;
  logic [nrle_pkg::WORD_W-1:0]          em_word;
  logic [7:0]                           em_octet;
  logic [1:0]                           oct_sel;
  nrle_pkg::res_t                       label;

  // Handshake and pipeline advance.
  assign s2_move = s2_valid && (!em_active || em_last);
  assign s1_move = s1_valid && (!s2_valid || s2_move);
  assign busy    = s1_valid && !s1_move;
  assign accept  = start && !busy;

  // Zero flag of each word, word 0 in the top bits of the 128-bit address.
  assign s1_addr = {s1_req.address_high, s1_req.address_low};

  always_comb begin
    for (int i = 0; i < nrle_pkg::NUM_WORDS; i++) begin
      zmask[i] = (s1_addr[(nrle_pkg::NUM_WORDS - 1 - i) * nrle_pkg::WORD_W +: nrle_pkg::WORD_W]
                  == '0);
    end
  end

  // One lane per word.
  for (genvar g = 0; g < nrle_pkg::NUM_WORDS; g++) begin : g_lane
    nrle_lane u_lane (
      .zmask    (zmask),
      .lane_idx (nrle_pkg::IDX_W'(g)),
      .run_len  (lane_runs[g])
    );
  end

  nrle_merge u_merge (
    .runs (s2_runs),
    .best (merged)
  );

  // Input and lane stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        s2_valid <= 1'b1;
      end else if (s2_move) begin
        s2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_req <= request;
    end
    if (s1_move) begin
      s2_v6   <= s1_req.is_ipv6;
      s2_plen <= s1_req.prefix_length;
      s2_addr <= s1_addr;
      s2_runs <= lane_runs;
    end
  end

  // Current label from the emitter state.
  assign em_word  = em_addr[{(3'd7 - em_idx), 4'b0000} +: nrle_pkg::WORD_W];
  assign oct_sel  = 2'd3 - em_idx[1:0];
  assign em_octet = em_addr[{2'b00, oct_sel, 3'b000} +: 8];
  assign em_is_zr = em_v6 && em_zr.found && (em_idx == em_zr.end_idx);

  always_comb begin
    label.label_kind  = nrle_pkg::KIND_PREFIX;
    label.label_value = {8'b0, em_plen};
    label.last_label  = 1'b0;
    em_idx_next       = em_idx - nrle_pkg::IDX_W'(1);
    if (em_prefix) begin
      label.label_kind  = nrle_pkg::KIND_PREFIX;
      label.label_value = {8'b0, em_plen};
      label.last_label  = 1'b0;
    end else if (!em_v6) begin
      label.label_kind  = nrle_pkg::KIND_OCTET;
      label.label_value = {8'b0, em_octet};
      label.last_label  = (em_idx == '0);
    end else if (em_is_zr) begin
      label.label_kind  = nrle_pkg::KIND_ZRUN;
      label.label_value = '0;
      label.last_label  = (em_zr.base_idx == '0);
      em_idx_next       = em_zr.base_idx - nrle_pkg::IDX_W'(1);
    end else begin
      label.label_kind  = nrle_pkg::KIND_WORD;
      label.label_value = em_word;
      label.last_label  = (em_idx == '0);
    end
  end

  assign em_last = em_active && label.last_label;

  // Emitter control and its copy of the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      em_active <= 1'b0;
      em_prefix <= 1'b0;
    end else if (s2_move) begin
      em_active <= 1'b1;
      em_prefix <= 1'b1;
    end else if (em_active) begin
      if (em_last) begin
        em_active <= 1'b0;
      end
      em_prefix <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      em_v6   <= s2_v6;
      em_plen <= s2_plen;
      em_addr <= s2_addr;
      em_zr   <= merged;
      em_idx  <= s2_v6 ? nrle_pkg::IDX_W'(nrle_pkg::NUM_WORDS - 1) : nrle_pkg::IDX_W'(3);
    end else if (em_active && !em_prefix) begin
      em_idx  <= em_idx_next;
    end
  end

  assign strobe = em_active;
  assign result = label;

  // The prefix label opens every train and is never its last label.
  a_prefix_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && result.label_kind == nrle_pkg::KIND_PREFIX |-> !result.last_label)
    else $error("prefix label marked last");

  // A train never breaks off between its first and last label.
  a_train_continues: assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last_label |=> strobe)
    else $error("label train interrupted");

  // A label after the last one of a train must be a new prefix.
  a_new_train_prefix: assert property (@(posedge clk) disable iff (rst)
    strobe && result.last_label ##1 strobe |-> result.label_kind == nrle_pkg::KIND_PREFIX)
    else $error("train did not open with a prefix");

  // A compressed run is never followed directly by another in the same train.
  a_single_zrun: assert property (@(posedge clk) disable iff (rst)
    strobe && result.label_kind == nrle_pkg::KIND_ZRUN && !result.last_label
    |=> !(strobe && result.label_kind == nrle_pkg::KIND_ZRUN))
    else $error("two compressed runs in a row");

  // An accepted request always lands in the input register.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> s1_valid)
    else $error("accepted request lost");

endmodule

`default_nettype wire
